// ----- design/bpp_pkg.sv -----
// shared types, constants and helper functions of the binomial put pricer
// used by bpp_mul, bpp_rows and binomial_put_pricer
package bpp_pkg;

    localparam int VAL_W         = 48;
    localparam int FAC_W         = 32;
    localparam int PROB_W        = 31;
    localparam int STEPS_W       = 9;
    localparam int HALF_W        = 24;
    localparam int FRAC_SHIFT    = 30;
    localparam int APB_ADDR_W    = 5;
    localparam int APB_DATA_W    = 32;
    localparam int DEF_MAX_STEPS = 256;

    localparam logic [FAC_W-1:0]  ONE_Q30  = 32'h4000_0000;
    localparam logic [PROB_W-1:0] HALF_Q30 = 31'h2000_0000;
    localparam logic [VAL_W-1:0]  VAL_MAX  = {VAL_W{1'b1}};

    typedef enum logic [2:0] {
        REG_STEPS        = 3'd0,
        REG_UP_FACTOR    = 3'd1,
        REG_DOWN_OVER_UP = 3'd2,
        REG_UP_INVERSE   = 3'd3,
        REG_PROB_UP      = 3'd4,
        REG_DISCOUNT     = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic done;
        logic sat;
    } mul_stat_t;

    function automatic logic [VAL_W-1:0] exercise(input logic [VAL_W-1:0] k,
                                                  input logic [VAL_W-1:0] s);
        return (k > s) ? (k - s) : '0;
    endfunction

endpackage

// ----- design/binomial_put_pricer.sv -----
// top level of the binomial put pricer: config registers, sequencer, result register
// instantiates bpp_mul and bpp_rows; depends on bpp_pkg
//
// Prices one put per request on a recombining tree of N = steps levels (zero taken as
// one, above MAX_STEPS clamped). All products run through one shared 48x32 q30
// multiplier. A request runs the u^N ramp (one product per level), the terminal walk
// (one product per node below the top), the rollback (one row read plus four products
// per node), then hands the result over and returns to idle to accept the next request.
// s_tready is high only while the sequencer is idle; the result sits in an output
// register, and the sequencer waits there if the previous result has not been taken.
// The user must write configuration over the APB port only while no request is in
// flight; the block itself does not enforce this.
module binomial_put_pricer #(
    parameter int MAX_STEPS = bpp_pkg::DEF_MAX_STEPS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bpp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bpp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [95:0]                     s_tdata,  // spot[47:0], strike[95:48]
    input  logic                            s_tuser,  // mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [47:0]                     m_tdata,  // option_value[47:0]
    output logic                            m_tuser   // overflow
);

    localparam int DEPTH = MAX_STEPS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int VW    = bpp_pkg::VAL_W;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RAMP = 9'b000000010,
        S_WALK = 9'b000000100,
        S_RD   = 9'b000001000,
        S_MP   = 9'b000010000,
        S_MQ   = 9'b000100000,
        S_MD   = 9'b001000000,
        S_MU   = 9'b010000000,
        S_FIN  = 9'b100000000
    } state_t;

    // configuration registers
    logic [bpp_pkg::STEPS_W-1:0] steps_reg;
    logic [bpp_pkg::FAC_W-1:0]   up_reg, dou_reg, uinv_reg, disc_reg;
    logic [bpp_pkg::PROB_W-1:0]  prob_reg;
    logic                        cfg_wr;
    logic [2:0]                  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg <= bpp_pkg::STEPS_W'(1);
            up_reg    <= bpp_pkg::ONE_Q30;
            dou_reg   <= bpp_pkg::ONE_Q30;
            uinv_reg  <= bpp_pkg::ONE_Q30;
            prob_reg  <= bpp_pkg::HALF_Q30;
            disc_reg  <= bpp_pkg::ONE_Q30;
        end else if (cfg_wr) begin
            case (cfg_idx)
                bpp_pkg::REG_STEPS:        steps_reg <= pwdata[bpp_pkg::STEPS_W-1:0];
                bpp_pkg::REG_UP_FACTOR:    up_reg    <= pwdata;
                bpp_pkg::REG_DOWN_OVER_UP: dou_reg   <= pwdata;
                bpp_pkg::REG_UP_INVERSE:   uinv_reg  <= pwdata;
                bpp_pkg::REG_PROB_UP:      prob_reg  <= pwdata[bpp_pkg::PROB_W-1:0];
                bpp_pkg::REG_DISCOUNT:     disc_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            bpp_pkg::REG_STEPS:        prdata = 32'(steps_reg);
            bpp_pkg::REG_UP_FACTOR:    prdata = up_reg;
            bpp_pkg::REG_DOWN_OVER_UP: prdata = dou_reg;
            bpp_pkg::REG_UP_INVERSE:   prdata = uinv_reg;
            bpp_pkg::REG_PROB_UP:      prdata = 32'(prob_reg);
            bpp_pkg::REG_DISCOUNT:     prdata = disc_reg;
            default:                   prdata = '0;
        endcase
    end

    // probability clamp to one, and its complement
    logic [bpp_pkg::FAC_W-1:0] p_fac, q_fac;
    assign p_fac = (32'(prob_reg) > bpp_pkg::ONE_Q30) ? bpp_pkg::ONE_Q30 : 32'(prob_reg);
    assign q_fac = bpp_pkg::ONE_Q30 - p_fac;

    // sequencer state
    state_t         state_reg, state_next;
    logic [AW-1:0]  n_reg, n_next;
    logic [AW-1:0]  j_reg, j_next;
    logic [AW-1:0]  lvl_reg, lvl_next;
    logic           pend_reg, pend_next;
    logic           sat_reg, sat_next;
    logic           mode_reg;
    logic [VW-1:0]  k_reg, s_reg, s_next, t_reg, t_next, res_reg, res_next;
    logic           ovf_out_reg, ovf_out_next;
    logic [VW-1:0]  out_reg;
    logic           m_valid_reg, m_valid_next;

    // multiplier
    logic                   mul_start, mul_state;
    logic [VW-1:0]          mul_a, mul_r;
    logic [bpp_pkg::FAC_W-1:0] mul_f;
    bpp_pkg::mul_stat_t     mul_stat;

    // rows
    logic           wr_en, rd_en;
    logic [AW-1:0]  wr_addr;
    logic [VW-1:0]  wr_price, wr_value;
    logic [VW-1:0]  price_a, value_a, value_b;
    logic [VW-1:0]  ex_val;
    logic [VW:0]    cont_sum;
    logic           accept;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign mul_state = state_reg inside {S_RAMP, S_WALK, S_MP, S_MQ, S_MD, S_MU};
    assign mul_start = mul_state && !pend_reg;
    assign ex_val    = bpp_pkg::exercise(k_reg, mul_r);
    assign cont_sum  = {1'b0, t_reg} + {1'b0, mul_r};

    always_comb begin
        mul_a = s_reg;
        mul_f = up_reg;
        case (state_reg)
            S_RAMP: begin mul_a = s_reg;   mul_f = up_reg;   end
            S_WALK: begin mul_a = s_reg;   mul_f = dou_reg;  end
            S_MP:   begin mul_a = value_a; mul_f = p_fac;    end
            S_MQ:   begin mul_a = value_b; mul_f = q_fac;    end
            S_MD:   begin mul_a = t_reg;   mul_f = disc_reg; end
            S_MU:   begin mul_a = price_a; mul_f = uinv_reg; end
            default: ;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        j_next       = j_reg;
        lvl_next     = lvl_reg;
        s_next       = s_reg;
        t_next       = t_reg;
        res_next     = res_reg;
        sat_next     = sat_reg;
        ovf_out_next = ovf_out_reg;
        m_valid_next = m_valid_reg;
        pend_next    = pend_reg;
        wr_en        = 1'b0;
        wr_addr      = j_reg;
        wr_price     = mul_r;
        wr_value     = ex_val;
        rd_en        = 1'b0;

        if (m_valid_reg && m_tready) m_valid_next = 1'b0;
        if (mul_start) pend_next = 1'b1;
        if (mul_stat.done) begin
            pend_next = 1'b0;
            if (mul_stat.sat) sat_next = 1'b1;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (steps_reg == '0) begin
                        n_next = AW'(1);
                    end else if (32'(steps_reg) > 32'(MAX_STEPS)) begin
                        n_next = AW'(MAX_STEPS);
                    end else begin
                        n_next = AW'(steps_reg);
                    end
                    s_next     = s_tdata[47:0];
                    j_next     = '0;
                    sat_next   = 1'b0;
                    state_next = S_RAMP;
                end
            end
            S_RAMP: begin
                if (mul_stat.done) begin
                    s_next = mul_r;
                    if (j_reg == n_reg - AW'(1)) begin
                        // top terminal node
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        j_next     = AW'(1);
                        state_next = S_WALK;
                    end else begin
                        j_next = j_reg + AW'(1);
                    end
                end
            end
            S_WALK: begin
                if (mul_stat.done) begin
                    s_next = mul_r;
                    wr_en  = 1'b1;
                    if (j_reg == n_reg) begin
                        lvl_next   = n_reg - AW'(1);
                        j_next     = '0;
                        state_next = S_RD;
                    end else begin
                        j_next = j_reg + AW'(1);
                    end
                end
            end
            S_RD: begin
                rd_en      = 1'b1;
                state_next = S_MP;
            end
            S_MP: begin
                if (mul_stat.done) begin
                    t_next     = mul_r;
                    state_next = S_MQ;
                end
            end
            S_MQ: begin
                if (mul_stat.done) begin
                    t_next     = cont_sum[VW-1:0];
                    state_next = S_MD;
                end
            end
            S_MD: begin
                if (mul_stat.done) begin
                    t_next     = mul_r;
                    state_next = S_MU;
                end
            end
            S_MU: begin
                if (mul_stat.done) begin
                    wr_en    = 1'b1;
                    wr_value = (mode_reg && ex_val > t_reg) ? ex_val : t_reg;
                    if (j_reg == lvl_reg) begin
                        if (lvl_reg == '0) begin
                            res_next   = wr_value;
                            state_next = S_FIN;
                        end else begin
                            lvl_next   = lvl_reg - AW'(1);
                            j_next     = '0;
                            state_next = S_RD;
                        end
                    end else begin
                        j_next     = j_reg + AW'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    ovf_out_next = sat_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        j_reg       <= j_next;
        lvl_reg     <= lvl_next;
        s_reg       <= s_next;
        t_reg       <= t_next;
        res_reg     <= res_next;
        sat_reg     <= sat_next;
        ovf_out_reg <= ovf_out_next;
        if (accept) begin
            k_reg    <= s_tdata[95:48];
            mode_reg <= s_tuser;
        end
        if (state_reg == S_FIN && (!m_valid_reg || m_tready)) out_reg <= res_reg;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = ovf_out_reg;

    bpp_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .f       (mul_f),
        .r       (mul_r),
        .stat    (mul_stat)
    );

    bpp_rows #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_rows (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_price  (wr_price),
        .wr_value  (wr_value),
        .rd_en     (rd_en),
        .rd_addr_a (j_reg),
        .rd_addr_b (j_reg + AW'(1)),
        .price_a   (price_a),
        .value_a   (value_a),
        .value_b   (value_b)
    );

    // a product only completes while the sequencer waits on one
    a_mul_done_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_stat.done |-> pend_reg)
        else $error("multiplier finished with no product pending");

    // row writes stay inside the tree of the current request
    a_wr_in_tree: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> wr_addr <= n_reg)
        else $error("row write beyond the terminal level");

    // rollback node index never passes the level being rebuilt
    a_roll_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD) |-> (j_reg <= lvl_reg && lvl_reg < n_reg))
        else $error("rollback node index out of range");

    // an accepted request closes the input straight after the transfer
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("input ready right after an accepted transfer");

endmodule

// ----- design/bpp_mul.sv -----
// shared q30 multiply unit: floor(a*f/2^30) saturated to 48 bits
// one 24x32 multiplier used twice per product; depends on bpp_pkg
module bpp_mul (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [bpp_pkg::VAL_W-1:0]    a,
    input  logic [bpp_pkg::FAC_W-1:0]    f,
    output logic [bpp_pkg::VAL_W-1:0]    r,
    output bpp_pkg::mul_stat_t           stat
);

    localparam int PROD_W = bpp_pkg::HALF_W + bpp_pkg::FAC_W;

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_HI   = 4'b0010,
        M_LO   = 4'b0100,
        M_SUM  = 4'b1000
    } mstate_t;

    mstate_t                        state_reg, state_next;
    logic [bpp_pkg::VAL_W-1:0]      a_reg;
    logic [bpp_pkg::FAC_W-1:0]      f_reg;
    logic [PROD_W-1:0]              hi_reg, lo_reg;
    logic [bpp_pkg::VAL_W-1:0]      r_reg;
    logic                           sat_reg, done_reg;
    logic [bpp_pkg::HALF_W-1:0]     op_half;
    logic [PROD_W-1:0]              prod;
    logic [PROD_W:0]                mid;
    logic [bpp_pkg::VAL_W+2:0]      sum;

    assign op_half = (state_reg == M_HI) ? a_reg[bpp_pkg::VAL_W-1:bpp_pkg::HALF_W]
                                         : a_reg[bpp_pkg::HALF_W-1:0];
    assign prod = PROD_W'(op_half) * PROD_W'(f_reg);

    // low six bits of the high product line up with the low product
    assign mid = {1'b0, hi_reg[5:0], {bpp_pkg::HALF_W{1'b0}}} + {1'b0, lo_reg};
    assign sum = (bpp_pkg::VAL_W+3)'(hi_reg[PROD_W-1:6])
               + (bpp_pkg::VAL_W+3)'(mid[PROD_W:bpp_pkg::FRAC_SHIFT]);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            M_IDLE: if (start) state_next = M_HI;
            M_HI:   state_next = M_LO;
            M_LO:   state_next = M_SUM;
            M_SUM:  state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == M_SUM);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == M_IDLE && start) begin
            a_reg <= a;
            f_reg <= f;
        end
        if (state_reg == M_HI) hi_reg <= prod;
        if (state_reg == M_LO) lo_reg <= prod;
        if (state_reg == M_SUM) begin
            sat_reg <= |sum[bpp_pkg::VAL_W+2:bpp_pkg::VAL_W];
            r_reg   <= (|sum[bpp_pkg::VAL_W+2:bpp_pkg::VAL_W]) ? bpp_pkg::VAL_MAX
                                                              : sum[bpp_pkg::VAL_W-1:0];
        end
    end

    assign r         = r_reg;
    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;

endmodule

// ----- design/bpp_rows.sv -----
// price and value rows of the tree, one write port, registered reads
// value row has two read ports (nodes j and j+1); depends on bpp_pkg
module bpp_rows #(
    parameter int DEPTH = bpp_pkg::DEF_MAX_STEPS + 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [bpp_pkg::VAL_W-1:0]  wr_price,
    input  logic [bpp_pkg::VAL_W-1:0]  wr_value,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr_a,
    input  logic [AW-1:0]              rd_addr_b,
    output logic [bpp_pkg::VAL_W-1:0]  price_a,
    output logic [bpp_pkg::VAL_W-1:0]  value_a,
    output logic [bpp_pkg::VAL_W-1:0]  value_b
);

    logic [bpp_pkg::VAL_W-1:0] price_mem [DEPTH];
    logic [bpp_pkg::VAL_W-1:0] value_mem [DEPTH];
    logic [bpp_pkg::VAL_W-1:0] price_a_reg, value_a_reg, value_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            price_mem[wr_addr] <= wr_price;
            value_mem[wr_addr] <= wr_value;
        end
        if (rd_en) begin
            price_a_reg <= price_mem[rd_addr_a];
            value_a_reg <= value_mem[rd_addr_a];
            value_b_reg <= value_mem[rd_addr_b];
        end
    end

    assign price_a = price_a_reg;
    assign value_a = value_a_reg;
    assign value_b = value_b_reg;

endmodule

// ----- tb/bpp_price_checker.sv -----
// watches the APB port and both stream channels of binomial_put_pricer, predicts each
// put value from the observed register writes and compares the results in order
// depends on bpp_pkg for widths, register indexes and fixed-point constants
module bpp_price_checker #(
    parameter int MAX_STEPS = bpp_pkg::DEF_MAX_STEPS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [bpp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bpp_pkg::APB_DATA_W-1:0]  pwdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [95:0]                     s_tdata,  // spot[47:0], strike[95:48]
    input  logic                            s_tuser,  // mode
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [47:0]                     m_tdata,  // option_value[47:0]
    input  logic                            m_tuser,  // overflow
    output int                              errors,
    output int                              pending
);
    import bpp_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] option_value;
        logic             overflow;
    } put_quote_t;

    logic [STEPS_W-1:0] cfg_steps;
    logic [FAC_W-1:0]   cfg_up, cfg_dou, cfg_uinv, cfg_disc;
    logic [PROB_W-1:0]  cfg_prob;
    put_quote_t         quotes_due[$];

    function automatic logic [VAL_W-1:0] qmul(input logic [VAL_W-1:0] a,
                                              input logic [FAC_W-1:0] f,
                                              inout logic sat);
        logic [VAL_W+FAC_W-1:0] prod;
        logic [VAL_W+FAC_W-1:0] r;
        prod = {{FAC_W{1'b0}}, a} * {{VAL_W{1'b0}}, f};
        r = prod >> FRAC_SHIFT;
        if (r > {{FAC_W{1'b0}}, VAL_MAX}) begin
            sat = 1'b1;
            return VAL_MAX;
        end
        return r[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] payoff(input logic [VAL_W-1:0] k,
                                                input logic [VAL_W-1:0] s);
        return (k > s) ? k - s : '0;
    endfunction

    function automatic put_quote_t price_put(input logic [VAL_W-1:0] s0,
                                             input logic [VAL_W-1:0] k,
                                             input logic american);
        logic [VAL_W-1:0] px [0:MAX_STEPS];
        logic [VAL_W-1:0] vx [0:MAX_STEPS];
        logic [VAL_W-1:0] s, c, e;
        logic [FAC_W-1:0] p, q;
        logic             sat;
        int               n;
        put_quote_t       res;
        n = int'(cfg_steps);
        if (n == 0) n = 1;
        if (n > MAX_STEPS) n = MAX_STEPS;
        p = ({1'b0, cfg_prob} > ONE_Q30) ? ONE_Q30 : {1'b0, cfg_prob};
        q = ONE_Q30 - p;
        sat = 1'b0;
        s = s0;
        for (int i = 0; i < n; i++) s = qmul(s, cfg_up, sat);
        px[0] = s;
        for (int j = 1; j <= n; j++) px[j] = qmul(px[j-1], cfg_dou, sat);
        for (int j = 0; j <= n; j++) vx[j] = payoff(k, px[j]);
        for (int lvl = n - 1; lvl >= 0; lvl--) begin
            for (int j = 0; j <= lvl; j++) begin
                c = qmul(vx[j], p, sat) + qmul(vx[j+1], q, sat);
                c = qmul(c, cfg_disc, sat);
                px[j] = qmul(px[j], cfg_uinv, sat);
                if (american) begin
                    e = payoff(k, px[j]);
                    if (e > c) c = e;
                end
                vx[j] = c;
            end
        end
        res.option_value = vx[0];
        res.overflow = sat;
        return res;
    endfunction

    always @(posedge aclk) begin
        put_quote_t want;
        if (!aresetn) begin
            cfg_steps <= 9'd1;
            cfg_up    <= ONE_Q30;
            cfg_dou   <= ONE_Q30;
            cfg_uinv  <= ONE_Q30;
            cfg_prob  <= HALF_Q30;
            cfg_disc  <= ONE_Q30;
            errors    <= 0;
            pending   <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_STEPS:        cfg_steps <= pwdata[STEPS_W-1:0];
                    REG_UP_FACTOR:    cfg_up    <= pwdata;
                    REG_DOWN_OVER_UP: cfg_dou   <= pwdata;
                    REG_UP_INVERSE:   cfg_uinv  <= pwdata;
                    REG_PROB_UP:      cfg_prob  <= pwdata[PROB_W-1:0];
                    REG_DISCOUNT:     cfg_disc  <= pwdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                quotes_due.push_back(price_put(s_tdata[47:0], s_tdata[95:48], s_tuser));
            if (m_tvalid && m_tready) begin
                if (quotes_due.size() == 0) begin
                    $error("result transfer with nothing expected: value %h overflow %b",
                           m_tdata, m_tuser);
                    errors <= errors + 1;
                end else begin
                    want = quotes_due.pop_front();
                    if (m_tdata !== want.option_value || m_tuser !== want.overflow) begin
                        if (m_tdata !== want.option_value)
                            $error("option_value: expected %h actual %h",
                                   want.option_value, m_tdata);
                        if (m_tuser !== want.overflow)
                            $error("overflow: expected %b actual %b", want.overflow, m_tuser);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= quotes_due.size();
        end
    end

endmodule

// ----- tb/binomial_put_pricer_test.sv -----
// top of the binomial_put_pricer testbench: clock, reset, APB writes, request and
// result stimulus with random gaps; depends on bpp_pkg, bpp_price_checker and the block
module binomial_put_pricer_test;
    import bpp_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam logic [47:0] FULL = 48'hFFFF_FFFF_FFFF;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0, pready;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0, prdata;
    logic        s_tvalid = 1'b0, s_tready, s_tuser = 1'b0;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid, m_tready = 1'b0, m_tuser;
    logic [47:0] m_tdata;
    int          errors, pending;
    int          cycles = 0;
    bit          tx_calm = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    binomial_put_pricer dut (.*);

    bpp_price_checker chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (10) @(posedge aclk);
    endtask

    task automatic load_tree(input logic [8:0] n, input logic [31:0] u, input logic [31:0] dou,
                             input logic [31:0] uinv, input logic [30:0] p,
                             input logic [31:0] disc);
        drain();
        write_reg(REG_STEPS, {23'd0, n});
        write_reg(REG_UP_FACTOR, u);
        write_reg(REG_DOWN_OVER_UP, dou);
        write_reg(REG_UP_INVERSE, uinv);
        write_reg(REG_PROB_UP, {1'b0, p});
        write_reg(REG_DISCOUNT, disc);
    endtask

    task automatic send_put(input logic [47:0] spot, input logic [47:0] strike, input logic am);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {strike, spot};
        s_tuser <= am;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // random realistic tree: u slightly above one, d/u = 1/u^2, p up to one; one tree in four takes random factors
    task automatic random_tree();
        logic [31:0] u, uinv, dou, disc;
        logic [63:0] t;
        logic [30:0] p;
        logic [8:0]  n;
        n = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(13, 24)) : 9'($urandom_range(1, 12));
        u = ONE_Q30 + $urandom_range(0, 32'h1000_0000);
        t = 64'h1000_0000_0000_0000 / u;
        uinv = t[31:0];
        t = ({32'd0, uinv} * {32'd0, uinv}) >> 30;
        dou = t[31:0];
        p = 31'($urandom_range(0, 32'h4000_0000));
        disc = ONE_Q30 - $urandom_range(0, 32'h0100_0000);
        if ($urandom_range(0, 3) == 0) begin
            u = $urandom; dou = $urandom; uinv = $urandom;
            p = 31'($urandom); disc = $urandom;
        end
        load_tree(n, u, dou, uinv, p, disc);
    endtask

    function automatic logic [47:0] rand_price();
        logic [47:0] v;
        v = 48'({$urandom, $urandom});
        return v >> $urandom_range(0, 24);
    endfunction

    // result side: random stalls, calm stretches and one long hold-off
    initial begin
        int gap;
        int taken;
        bit calm;
        taken = 0;
        calm = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken % 15 == 0) calm = ($urandom_range(0, 2) == 0);
            gap = calm ? 0 : $urandom_range(0, 16);
            if (taken == 20) gap = 4000;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            taken++;
        end
    end

    initial begin
        logic [47:0] spot, strike;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset tree: one flat step
        send_put('0, '0, 1'b0);
        send_put('0, FULL, 1'b1);
        send_put(FULL, '0, 1'b0);
        send_put(FULL, FULL, 1'b1);
        send_put(48'd100 << 24, 48'd110 << 24, 1'b0);
        send_put(48'd100 << 24, 48'd110 << 24, 1'b1);
        send_put(48'd120 << 24, 48'd110 << 24, 1'b1);

        // zero steps, all factors at their top: price and value saturation, p above one
        load_tree(9'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
                  32'hFFFF_FFFF);
        send_put(FULL, FULL, 1'b0);
        send_put(48'd1 << 24, FULL, 1'b1);
        send_put(48'd1, 48'hFFFF_0000_0000, 1'b0);
        send_put('0, FULL, 1'b1);

        // all factors zero
        load_tree(9'd3, '0, '0, '0, '0, '0);
        send_put(48'd50 << 24, 48'd60 << 24, 1'b0);
        send_put(48'd50 << 24, 48'd60 << 24, 1'b1);

        // steps above the maximum, clamped to the deepest tree
        load_tree(9'h1FF, 32'h4147_AE14, 32'h3C4C_EB4E, 32'h3EBF_D8E5, 31'h2100_0000,
                  32'h3FF0_0000);
        send_put(48'd100 << 24, 48'd105 << 24, 1'b1);

        // ordinary trees, long calm run included
        load_tree(9'd4, 32'h4200_0000, 32'h3C3C_3C3C, 32'h3E0F_83E1, 31'h2200_0000,
                  32'h3FF0_0000);
        tx_calm = 1;
        for (int i = 0; i < 6; i++) send_put(48'd100 << 24, 48'(90 + 5 * i) << 24, i[0]);
        tx_calm = 0;

        for (int c = 0; c < 8; c++) begin
            random_tree();
            tx_calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 12; i++) begin
                spot = rand_price();
                case ($urandom_range(0, 3))
                    0: strike = rand_price();
                    1: strike = 48'({$urandom, $urandom});
                    default: strike = spot + 48'($urandom_range(0, 32'h0800_0000)) -
                                      48'h0400_0000;
                endcase
                if ($urandom_range(0, 7) == 0) spot = 48'({$urandom, $urandom});
                send_put(spot, strike, 1'($urandom));
            end
        end

        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
design/bpp_pkg.sv
design/bpp_mul.sv
design/bpp_rows.sv
design/binomial_put_pricer.sv
tb/bpp_price_checker.sv
tb/binomial_put_pricer_test.sv
